// File: src/cwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clique witness transition package
// Shared types, command codes and small label and pair helper functions.
// ----------------------------------------------------------------------------
package cwt_pkg;

	localparam int LABEL_SLOTS = 8;
	localparam int MAX_LABELS  = 8;
	localparam int EDGE_BITS   = 28;

	localparam logic [1:0] CMD_INTRO_VERTEX = 2'd0;
	localparam logic [1:0] CMD_INTRO_EDGE   = 2'd1;
	localparam logic [1:0] CMD_FORGET       = 2'd2;
	localparam logic [1:0] CMD_JOIN         = 2'd3;

	typedef logic [EDGE_BITS-1:0] edges_t;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] vertex_a;
		logic [2:0] vertex_b;
		logic       found_a;
		edges_t     edges_a;
		logic       found_b;
		edges_t     edges_b;
	} cwt_item_t;

	typedef struct packed {
		logic   witness_valid;
		logic   found_out;
		edges_t edges_out;
		logic   loop_error;
	} cwt_result_t;

	typedef struct packed {
		logic [LABEL_SLOTS-1:0] vset;
		logic [3:0]             nv;
		logic [4:0]             ne;
		logic [3:0]             nbr_cnt;
	} cwt_stats_t;

	function automatic logic [4:0] pair_index(logic [2:0] a, logic [2:0] b);
		logic [2:0] lo;
		logic [2:0] hi;
		logic [4:0] base;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case (hi)
			3'd0:    base = 5'd0;
			3'd1:    base = 5'd0;
			3'd2:    base = 5'd1;
			3'd3:    base = 5'd3;
			3'd4:    base = 5'd6;
			3'd5:    base = 5'd10;
			3'd6:    base = 5'd15;
			3'd7:    base = 5'd21;
			default: base = 5'd0;
		endcase
		return base + {2'b00, lo};
	endfunction

	function automatic logic label_ok(logic [2:0] v);
		return int'(v) < MAX_LABELS;
	endfunction

	function automatic edges_t usable_mask();
		edges_t m;
		m = '0;
		for (int j = 1; j < LABEL_SLOTS; j++) begin
			for (int i = 0; i < j; i++) begin
				if (j < MAX_LABELS) begin
					m[pair_index(3'(i), 3'(j))] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	function automatic logic [4:0] full_edges(logic [3:0] k);
		case (k)
			4'd2:    return 5'd1;
			4'd3:    return 5'd3;
			4'd4:    return 5'd6;
			4'd5:    return 5'd10;
			4'd6:    return 5'd15;
			4'd7:    return 5'd21;
			4'd8:    return 5'd28;
			default: return 5'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: src/cwt_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clique witness statistics
// Vertex set, vertex count, edge count and neighbor count of one edge bitmap.
// ----------------------------------------------------------------------------
module cwt_stats (
	input  wire cwt_pkg::edges_t     edges,
	input  wire logic [2:0]          vertex,
	output cwt_pkg::cwt_stats_t      stats
);

	logic [cwt_pkg::LABEL_SLOTS-1:0][cwt_pkg::LABEL_SLOTS-1:0] adj;
	logic [cwt_pkg::LABEL_SLOTS-1:0] row;

	always_comb begin
		adj = '0;
		for (int j = 1; j < cwt_pkg::LABEL_SLOTS; j++) begin
			for (int i = 0; i < j; i++) begin
				adj[i][j] = edges[cwt_pkg::pair_index(3'(i), 3'(j))];
				adj[j][i] = edges[cwt_pkg::pair_index(3'(i), 3'(j))];
			end
		end
	end

	assign row = adj[vertex];

	always_comb begin
		stats = '0;
		for (int v = 0; v < cwt_pkg::LABEL_SLOTS; v++) begin
			stats.vset[v] = |adj[v];
		end
		stats.nv      = 4'($countones(stats.vset));
		stats.ne      = 5'($countones(edges));
		stats.nbr_cnt = 4'($countones(row));
	end

endmodule
`default_nettype wire

// File: src/cwt_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clique witness transition evaluator
// Computes the successor witness of one registered transaction.
// ----------------------------------------------------------------------------
module cwt_eval (
	input  wire cwt_pkg::cwt_item_t  item,
	input  wire logic [3:0]          clique_size,
	output cwt_pkg::cwt_result_t     result
);

	cwt_pkg::edges_t     ea;
	cwt_pkg::edges_t     eb;
	cwt_pkg::edges_t     sel_edges;
	cwt_pkg::edges_t     edge_bit;
	cwt_pkg::cwt_stats_t st;
	logic [3:0]          k;
	logic [4:0]          full;
	logic [4:0]          nv5;
	logic [4:0]          k5;
	logic [5:0]          ne_next;
	logic [4:0]          after;
	logic [3:0]          nbr;
	logic                ina;
	logic                inb;
	logic                grow;

	assign ea = item.edges_a & cwt_pkg::usable_mask();
	assign eb = item.edges_b & cwt_pkg::usable_mask();
	assign sel_edges = (item.command == cwt_pkg::CMD_JOIN) ? (ea | eb) : ea;

	cwt_stats u_stats (
		.edges  (sel_edges),
		.vertex (item.vertex_a),
		.stats  (st)
	);

	assign k = (clique_size < 4'd2) ? 4'd2 : ((clique_size > 4'd8) ? 4'd8 : clique_size);
	assign full = cwt_pkg::full_edges(k);
	assign nv5 = {1'b0, st.nv};
	assign k5 = {1'b0, k};
	assign edge_bit = cwt_pkg::edges_t'(1) << cwt_pkg::pair_index(item.vertex_a, item.vertex_b);
	assign ina = st.vset[item.vertex_a];
	assign inb = st.vset[item.vertex_b];
	assign ne_next = {1'b0, st.ne} + 6'd1;
	assign nbr = cwt_pkg::label_ok(item.vertex_a) ? st.nbr_cnt : 4'd0;

	always_comb begin
		grow  = 1'b1;
		after = nv5;
		if (ina && inb) begin
			after = nv5;
		end else if ((ina || inb) && (nv5 < k5)) begin
			after = nv5 + 5'd1;
		end else if (!ina && !inb && ((nv5 + 5'd1) < k5)) begin
			after = nv5 + 5'd2;
		end else begin
			grow = 1'b0;
		end
	end

	always_comb begin
		result = '0;
		case (item.command)
			cwt_pkg::CMD_INTRO_VERTEX: begin
				result.witness_valid = 1'b1;
				result.found_out     = item.found_a;
				result.edges_out     = item.found_a ? '0 : ea;
			end
			cwt_pkg::CMD_INTRO_EDGE: begin
				if (item.found_a) begin
					result.witness_valid = 1'b1;
					result.found_out     = 1'b1;
				end else if (item.vertex_a == item.vertex_b) begin
					result.loop_error = 1'b1;
				end else if (!cwt_pkg::label_ok(item.vertex_a)
						|| !cwt_pkg::label_ok(item.vertex_b)) begin
					result = '0;
				end else if ((ea & edge_bit) != '0) begin
					result.witness_valid = 1'b1;
					result.edges_out     = ea;
				end else if (grow) begin
					result.witness_valid = 1'b1;
					if ((after == k5) && (ne_next == {1'b0, full})) begin
						result.found_out = 1'b1;
					end else begin
						result.edges_out = ea | edge_bit;
					end
				end
			end
			cwt_pkg::CMD_FORGET: begin
				if (item.found_a) begin
					result.witness_valid = 1'b1;
					result.found_out     = 1'b1;
				end else if ((nbr == (k - 4'd1)) || (nbr == 4'd0)) begin
					result.witness_valid = 1'b1;
					result.edges_out     = ea;
				end
			end
			cwt_pkg::CMD_JOIN: begin
				if (item.found_a || item.found_b) begin
					result.witness_valid = 1'b1;
					result.found_out     = 1'b1;
				end else if ((st.nv == k) && (st.ne == full)) begin
					result.witness_valid = 1'b1;
					result.found_out     = 1'b1;
				end else if ((st.nv <= k) && (st.ne != full)) begin
					result.witness_valid = 1'b1;
					result.edges_out     = sel_edges;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/clique_witness_transition_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clique witness transition
// One tree-decomposition step of a clique search: successor witness or reject.
//
// Channel   Handshake          Payload
// config    cfg_we             cfg_wdata (clique size k)
// command   start / busy       item
// result    done               result
//
// A transaction is accepted at every clock edge where start is high; busy is
// always low. Results appear on done one per cycle, after the input register
// and the result register. Reset clears the pipeline valid flags and loads
// clique size 3. The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module clique_witness_transition_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [3:0]           cfg_wdata,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cwt_pkg::cwt_item_t   item,
	output logic                      done,
	output cwt_pkg::cwt_result_t      result
);

	logic [3:0]           clique_size_q;
	logic                 valid_s1;
	cwt_pkg::cwt_item_t   item_s1;
	cwt_pkg::cwt_result_t eval_res;
	logic                 done_s2;
	cwt_pkg::cwt_result_t result_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clique_size_q <= 4'd3;
		end else if (cfg_we) begin
			clique_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result_s2 <= eval_res;
		end
	end

	cwt_eval u_eval (
		.item        (item_s1),
		.clique_size (clique_size_q),
		.result      (eval_res)
	);

	assign done   = done_s2;
	assign result = result_s2;

endmodule
`default_nettype wire
